// File: design/srr_pkg.sv
// Shared types and constants for the selective-repeat receiver.
// No dependencies; imported by every module of the block.
package srr_pkg;

  localparam int SEQ_COUNT    = 8;
  localparam int SEQ_W        = $clog2(SEQ_COUNT);
  localparam int WINDOW       = 4;
  localparam int PAYLOAD_BITS = 32;
  localparam int MAX_DRAIN    = 3;
  localparam int DRAIN_W      = 2;
  localparam int Q_DEPTH      = 2;
  localparam int Q_AW         = 1;

  localparam int IN_TDATA_W   = ((SEQ_W + PAYLOAD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((SEQ_W + PAYLOAD_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_W  = 5;

  typedef enum logic [2:0] {
    ST_IN_ORDER   = 3'd0,
    ST_FROM_BUF   = 3'd1,
    ST_BUFFERED   = 3'd2,
    ST_CORRUPT    = 3'd3,
    ST_DUPLICATE  = 3'd4,
    ST_OUT_OF_WIN = 3'd5
  } status_t;

  // One classified frame, handed from the front to the back.
  typedef struct packed {
    status_t                  status;
    logic [SEQ_W-1:0]         seq;
    logic [PAYLOAD_BITS-1:0]  payload;
    logic [DRAIN_W-1:0]       drain_cnt;
  } job_t;

endpackage

// File: design/srr_front.sv
// Front end: classifies each accepted frame against the window and updates
// expected sequence number and held flags. Depends on srr_pkg.
module srr_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [srr_pkg::SEQ_W-1:0]      frame_seq,
  input  logic                           crc_good,
  input  logic [srr_pkg::PAYLOAD_BITS-1:0] payload,
  output srr_pkg::job_t                  job
);
  import srr_pkg::*;

  logic [SEQ_W-1:0]     expected_r, expected_nxt;
  logic [SEQ_COUNT-1:0] held_r, held_nxt;
  logic [SEQ_W-1:0]     offset;
  logic [SEQ_W-1:0]     e1, e2, e3;
  logic [DRAIN_W-1:0]   cnt;
  logic [SEQ_COUNT-1:0] after_clear;

  always_comb begin
    offset       = frame_seq - expected_r;
    e1           = expected_r + SEQ_W'(1);
    e2           = expected_r + SEQ_W'(2);
    e3           = expected_r + SEQ_W'(3);
    expected_nxt = expected_r;
    held_nxt     = held_r;
    after_clear  = held_r;
    after_clear[frame_seq] = 1'b0;
    cnt          = '0;
    job.seq       = frame_seq;
    job.payload   = payload;
    job.drain_cnt = '0;
    job.status    = ST_OUT_OF_WIN;

    // count consecutive held frames right after the expected one
    if (after_clear[e1]) begin
      cnt = DRAIN_W'(1);
      if (after_clear[e2]) begin
        cnt = DRAIN_W'(2);
        if (after_clear[e3]) cnt = DRAIN_W'(MAX_DRAIN);
      end
    end

    if (!crc_good) begin
      job.status = ST_CORRUPT;
    end else if (offset == '0) begin
      job.status    = ST_IN_ORDER;
      job.drain_cnt = cnt;
      held_nxt      = after_clear;
      if (cnt >= DRAIN_W'(1)) held_nxt[e1] = 1'b0;
      if (cnt >= DRAIN_W'(2)) held_nxt[e2] = 1'b0;
      if (cnt >= DRAIN_W'(3)) held_nxt[e3] = 1'b0;
      expected_nxt  = expected_r + SEQ_W'(1) + SEQ_W'(cnt);
    end else if (offset < SEQ_W'(WINDOW)) begin
      if (held_r[frame_seq]) begin
        job.status = ST_DUPLICATE;
      end else begin
        job.status          = ST_BUFFERED;
        held_nxt[frame_seq] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      held_r     <= '0;
    end else if (accept) begin
      expected_r <= expected_nxt;
      held_r     <= held_nxt;
    end
  end

endmodule

// File: design/srr_queue.sv
// Short job queue between front and back ends.
// Depends on srr_pkg for the job type and depth.
module srr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  srr_pkg::job_t push_job,
  input  logic          pop,
  output srr_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);
  import srr_pkg::*;

  job_t             entries [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]    count_r;

  assign full     = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = entries[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      if (push && !pop)      count_r <= count_r + (Q_AW+1)'(1);
      else if (pop && !push) count_r <= count_r - (Q_AW+1)'(1);
    end
  end

endmodule

// File: design/srr_back.sv
// Back end: writes and drains the payload buffer and drives the result
// register. Depends on srr_pkg.
module srr_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             job_avail,
  input  srr_pkg::job_t                    job,
  output logic                             job_pop,
  output logic                             res_valid,
  input  logic                             res_ready,
  output srr_pkg::status_t                 res_status,
  output logic                             res_ack,
  output logic [srr_pkg::SEQ_W-1:0]        res_seq,
  output logic                             res_deliver,
  output logic [srr_pkg::PAYLOAD_BITS-1:0] res_payload,
  output logic                             res_last
);
  import srr_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_READ, B_EMIT} bstate_t;

  logic [PAYLOAD_BITS-1:0] mem [SEQ_COUNT];
  logic [PAYLOAD_BITS-1:0] rd_data_r;

  bstate_t                 state_r;
  logic [SEQ_W-1:0]        addr_r;
  logic [DRAIN_W-1:0]      left_r;
  logic                    valid_r;
  status_t                 status_r;
  logic                    ack_r, deliver_r, last_r;
  logic [SEQ_W-1:0]        seq_r;
  logic [PAYLOAD_BITS-1:0] payload_r;
  logic                    out_free;
  logic                    job_dlv;
  logic                    res_load;

  assign out_free = !valid_r || res_ready;
  assign job_pop  = (state_r == B_IDLE) && job_avail && out_free;
  assign job_dlv  = (job.status == ST_IN_ORDER);
  assign res_load = job_pop || ((state_r == B_EMIT) && out_free);

  always_ff @(posedge clk) begin
    if (job_pop && job.status == ST_BUFFERED) mem[job.seq] <= job.payload;
    rd_data_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
      addr_r  <= '0;
      left_r  <= '0;
    end else begin
      if (res_load) valid_r <= 1'b1;
      else if (res_ready) valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (job_pop) begin
            status_r  <= job.status;
            ack_r     <= job_dlv || job.status == ST_BUFFERED;
            seq_r     <= job.seq;
            deliver_r <= job_dlv;
            payload_r <= job_dlv ? job.payload : '0;
            last_r    <= (job.drain_cnt == '0);
            addr_r    <= job.seq + SEQ_W'(1);
            left_r    <= job.drain_cnt;
            if (job.drain_cnt != '0) state_r <= B_READ;
          end
        end
        B_READ: state_r <= B_EMIT;
        B_EMIT: begin
          if (out_free) begin
            status_r  <= ST_FROM_BUF;
            ack_r     <= 1'b1;
            seq_r     <= addr_r;
            deliver_r <= 1'b1;
            payload_r <= rd_data_r;
            last_r    <= (left_r == DRAIN_W'(1));
            addr_r    <= addr_r + SEQ_W'(1);
            left_r    <= left_r - DRAIN_W'(1);
            // advance to the next held entry, or finish the job
            state_r   <= (left_r == DRAIN_W'(1)) ? B_IDLE : B_READ;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign res_valid   = valid_r;
  assign res_status  = status_r;
  assign res_ack     = ack_r;
  assign res_seq     = seq_r;
  assign res_deliver = deliver_r;
  assign res_payload = payload_r;
  assign res_last    = last_r;

endmodule

// File: design/selective_repeat_receiver_top.sv
// Channel   Direction  Handshake                Content
// in_*      slave      in_tvalid / in_tready    one frame: seq, payload, crc flag
// out_*     master     out_tvalid / out_tready  one result, out_tlast on the final one
//
// A frame yields 1 to 4 results. The back end loads the first result
// directly and emits each drained buffer entry after a registered buffer
// read (B_READ, then B_EMIT). A two-entry job queue lets the front keep
// accepting frames while results wait. rst_n is synchronous, active low, and
// clears expected sequence, held flags, queue and output valid.
// Depends on srr_pkg, srr_front, srr_queue and srr_back.
module selective_repeat_receiver_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] frame_seq, [34:3] payload, [39:35] zero
  input  logic [srr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] crc_good
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] ack_seq, [34:3] payload_out, [39:35] zero
  output logic [srr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [2:0] status, [3] ack_valid, [4] deliver_valid
  output logic [srr_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                               out_tlast
);
  import srr_pkg::*;

  job_t                    front_job, head_job;
  logic                    accept, q_full, q_empty, pop;
  status_t                 r_status;
  logic                    r_ack, r_dlv;
  logic [SEQ_W-1:0]        r_seq;
  logic [PAYLOAD_BITS-1:0] r_payload;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  srr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .frame_seq (in_tdata[SEQ_W-1:0]),
    .crc_good  (in_tuser),
    .payload   (in_tdata[SEQ_W+PAYLOAD_BITS-1:SEQ_W]),
    .job       (front_job)
  );

  srr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_job (front_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  srr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_avail   (!q_empty),
    .job         (head_job),
    .job_pop     (pop),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_status  (r_status),
    .res_ack     (r_ack),
    .res_seq     (r_seq),
    .res_deliver (r_dlv),
    .res_payload (r_payload),
    .res_last    (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W-SEQ_W-PAYLOAD_BITS){1'b0}}, r_payload, r_seq};
  assign out_tuser = {r_dlv, r_ack, r_status};

endmodule

// File: test/tb_selective_repeat_receiver_top.sv
// Testbench for selective_repeat_receiver_top: directed and random frames with
// random stream stalls, checked result by result against a local predictor.
// Depends on srr_pkg and the design sources.
`timescale 1ns / 1ps

module tb_selective_repeat_receiver_top;
  import srr_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 80;
  localparam int MAX_REPORTS = 10;

  typedef logic [SEQ_W-1:0]        seq_t;
  typedef logic [PAYLOAD_BITS-1:0] word_t;

  typedef struct {
    status_t status;
    bit      ack_valid;
    seq_t    ack_seq;
    bit      deliver_valid;
    word_t   payload;
    bit      last;
  } rx_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  // receiver state as the predictor sees it
  seq_t       rx_next_seq;
  bit         rx_held [SEQ_COUNT];
  word_t      rx_held_word [SEQ_COUNT];
  rx_result_t pending_results[$];

  bit in_idle_en  = 1'b0;
  bit out_idle_en = 1'b0;
  bit long_hold_req = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;

  selective_repeat_receiver_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void push_result(status_t st, bit ack, seq_t sq, bit dv, word_t w);
    rx_result_t r;
    r.status        = st;
    r.ack_valid     = ack;
    r.ack_seq       = sq;
    r.deliver_valid = dv;
    r.payload       = dv ? w : '0;
    r.last          = 1'b0;
    pending_results.push_back(r);
  endfunction

  // Work out the results of one accepted frame and advance the receiver state.
  function automatic void predict_frame(seq_t sq, bit good, word_t w);
    seq_t offset;
    seq_t nxt;
    int   n;
    offset = sq - rx_next_seq;
    n = 0;
    if (!good) begin
      push_result(ST_CORRUPT, 1'b0, sq, 1'b0, '0);
    end else if (offset == 0) begin
      rx_held[sq] = 1'b0;
      push_result(ST_IN_ORDER, 1'b1, sq, 1'b1, w);
      n = 1;
      nxt = sq + seq_t'(1);
      while (n < MAX_DRAIN + 1 && rx_held[nxt]) begin
        rx_held[nxt] = 1'b0;
        push_result(ST_FROM_BUF, 1'b1, nxt, 1'b1, rx_held_word[nxt]);
        n++;
        nxt = nxt + seq_t'(1);
      end
      rx_next_seq = nxt;
    end else if (offset < WINDOW) begin
      if (!rx_held[sq]) begin
        rx_held[sq] = 1'b1;
        rx_held_word[sq] = w;
        push_result(ST_BUFFERED, 1'b1, sq, 1'b0, '0);
      end else begin
        push_result(ST_DUPLICATE, 1'b0, sq, 1'b0, '0);
      end
    end else begin
      push_result(ST_OUT_OF_WIN, 1'b0, sq, 1'b0, '0);
    end
    pending_results[pending_results.size()-1].last = 1'b1;
  endfunction

  // Offer one frame, hold it until the transfer, then predict its results.
  task automatic send_frame(input seq_t sq, input bit good, input word_t w);
    if (in_idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({w, sq});
    in_tuser  <= good;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_frame(sq, good, w);
  endtask

  // Mostly frames inside the window, so buffering and draining happen often.
  task automatic send_random_frame();
    int   pick;
    seq_t sq;
    bit   good;
    pick = $urandom_range(0, 99);
    good = 1'b1;
    if (pick < 12) begin
      sq = seq_t'($urandom);
      good = 1'b0;
    end else if (pick < 27) begin
      sq = seq_t'($urandom);
    end else begin
      sq = rx_next_seq + seq_t'($urandom_range(0, WINDOW - 1));
    end
    send_frame(sq, good, $urandom);
  endtask

  task automatic wait_results_done();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Walk every status, window edges, a full three-frame drain and wrap.
  task automatic test_directed();
    send_frame(3'd0, 1'b1, 32'h0000_0000);
    send_frame(3'd1, 1'b0, 32'hFFFF_FFFF);
    send_frame(3'd1, 1'b1, 32'hFFFF_FFFF);
    send_frame(3'd7, 1'b1, $urandom);
    send_frame(3'd5, 1'b1, 32'hA5A5_A5A5);
    send_frame(3'd4, 1'b1, 32'h5A5A_5A5A);
    send_frame(3'd3, 1'b1, 32'hFFFF_FFFF);
    send_frame(3'd3, 1'b1, $urandom);
    send_frame(3'd5, 1'b0, $urandom);
    send_frame(3'd2, 1'b1, 32'h0000_0001);
    send_frame(3'd7, 1'b1, $urandom);
    send_frame(3'd0, 1'b1, $urandom);
    send_frame(3'd1, 1'b1, $urandom);
    send_frame(3'd2, 1'b1, $urandom);
    send_frame(3'd6, 1'b1, 32'h8000_0000);
    send_frame(3'd5, 1'b1, $urandom);
    send_frame(3'd3, 1'b1, $urandom);
    send_frame(3'd2, 1'b1, $urandom);
    send_frame(3'd4, 1'b1, $urandom);
    send_frame(3'd7, 1'b1, $urandom);
    send_frame(3'd7, 1'b1, $urandom);
    send_frame(3'd6, 1'b1, 32'h0000_0000);
    send_frame(3'd1, 1'b0, $urandom);
    send_frame(3'd0, 1'b1, $urandom);
  endtask

  // Hold off the result side long enough that the input stalls.
  task automatic test_backpressure();
    long_hold_req = 1'b1;
    repeat (24) send_random_frame();
  endtask

  // Pause the sender until every result is back, then resume.
  task automatic test_sender_pause();
    stop_sending();
    wait_results_done();
    repeat (12) send_random_frame();
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random_frame();
  endtask

  always @(posedge clk) begin
    int hold_left;
    int stall_left;
    if (long_hold_req) begin
      hold_left = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (out_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [PAYLOAD_BITS-1:0] exp_val,
                                      logic [PAYLOAD_BITS-1:0] got_val);
    if (exp_val !== got_val) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %s: expected %0h, got %0h", name, exp_val, got_val);
    end
  endfunction

  always @(posedge clk) begin
    rx_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: tuser %0h tdata %0h", out_tuser, out_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", PAYLOAD_BITS'(exp_r.status), PAYLOAD_BITS'(out_tuser[2:0]));
        check_field("ack_valid", PAYLOAD_BITS'(exp_r.ack_valid),
                    PAYLOAD_BITS'(out_tuser[3]));
        check_field("deliver_valid", PAYLOAD_BITS'(exp_r.deliver_valid),
                    PAYLOAD_BITS'(out_tuser[4]));
        check_field("ack_seq", PAYLOAD_BITS'(exp_r.ack_seq),
                    PAYLOAD_BITS'(out_tdata[SEQ_W-1:0]));
        check_field("payload_out", exp_r.payload, out_tdata[SEQ_W +: PAYLOAD_BITS]);
        check_field("last", PAYLOAD_BITS'(exp_r.last), PAYLOAD_BITS'(out_tlast));
      end
    end
  end

  initial begin
    rx_next_seq = '0;
    foreach (rx_held[i]) rx_held[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    test_directed();
    test_backpressure();
    test_sender_pause();
    test_random(260);

    // no idling for the tail of the run
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    test_random(60);

    stop_sending();
    wait_results_done();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
